FILE: sv/thkm_pkg.sv
package thkm_pkg;

  localparam int MAX_KEYS     = 4;
  localparam int SLOTS_IN_REG = 4;
  localparam int KEY_SLOTS    = (MAX_KEYS < SLOTS_IN_REG) ? MAX_KEYS : SLOTS_IN_REG;
  localparam int SLOT_W       = 16;
  localparam int IDX_W        = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int CNT_W        = 3;
  localparam int THR_W        = 16;
  localparam int TIME_W       = 17;
  localparam int DELTA_W      = 10;
  localparam int DEV_W        = 6;
  localparam int CODE_W       = 10;
  localparam int DATA_W       = 64;
  localparam int ADDR_W       = 6;
  localparam int REG_SEL_W    = 3;

  localparam logic [REG_SEL_W-1:0] REG_HOLD_LIMIT      = 3'd0;
  localparam logic [REG_SEL_W-1:0] REG_PRIMARY_KEYS    = 3'd1;
  localparam logic [REG_SEL_W-1:0] REG_PRIMARY_COUNT   = 3'd2;
  localparam logic [REG_SEL_W-1:0] REG_SECONDARY_KEYS  = 3'd3;
  localparam logic [REG_SEL_W-1:0] REG_SECONDARY_COUNT = 3'd4;

  localparam logic OP_LEVEL = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic KIND_KEY  = 1'b0;
  localparam logic KIND_SYNC = 1'b1;

  typedef enum logic [1:0] {
    SEG_FIRST,
    SEG_SECOND,
    SEG_SYNC
  } seg_t;

  // Output words planned for one input item: a first key list, an optional
  // second list of primary releases and an optional sync marker.
  typedef struct packed {
    logic             first_secondary;
    logic             first_value;
    logic [CNT_W-1:0] first_count;
    logic [CNT_W-1:0] second_count;
    logic             sync;
  } plan_t;

  typedef struct packed {
    logic             load;
    seg_t             seg;
    logic [IDX_W-1:0] idx;
    logic             last;
  } cmd_t;

  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] count);
    logic [CNT_W-1:0] lim;
    lim = CNT_W'(KEY_SLOTS);
    return (count > lim) ? lim : count;
  endfunction

endpackage

FILE: sv/tap_hold_key_mapper.sv
// Channel   Handshake               Payload
// input     in_valid / in_ready     op, pressed, elapsed_ms
// output    out_valid / out_ready   kind, dev_num, key_code, key_value, last
// config    psel/penable/pwrite     paddr, pwdata, prdata, pready (64-bit regs at 8*i)
//
// An input word is accepted in one cycle and planned in the next; then one output
// word per cycle is loaded into the output register while the output is not stalled,
// up to eight per input.
// A stalled output holds the controller in its state; the next input is taken
// once the last result is in the output register.
// Synchronous reset clears the button state, hold counter and non-payload registers.
module tap_hold_key_mapper (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             op,
  input  logic                             pressed,
  input  logic [thkm_pkg::DELTA_W-1:0]     elapsed_ms,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             kind,
  output logic [thkm_pkg::DEV_W-1:0]       dev_num,
  output logic [thkm_pkg::CODE_W-1:0]      key_code,
  output logic                             key_value,
  output logic                             last,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [thkm_pkg::ADDR_W-1:0]      paddr,
  input  logic [thkm_pkg::DATA_W-1:0]      pwdata,
  output logic [thkm_pkg::DATA_W-1:0]      prdata,
  output logic                             pready
);
  import thkm_pkg::*;

  plan_t                plan;
  cmd_t                 cmd;
  logic                 accept;
  logic                 cfg_write;
  logic [REG_SEL_W-1:0] cfg_sel;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_sel   = paddr[ADDR_W-1 -: REG_SEL_W];

  thkm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .plan      (plan),
    .accept    (accept),
    .cmd       (cmd)
  );

  thkm_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .op         (op),
    .pressed    (pressed),
    .elapsed_ms (elapsed_ms),
    .cmd        (cmd),
    .plan       (plan),
    .cfg_write  (cfg_write),
    .cfg_sel    (cfg_sel),
    .cfg_wdata  (pwdata),
    .cfg_rdata  (prdata),
    .kind       (kind),
    .dev_num    (dev_num),
    .key_code   (key_code),
    .key_value  (key_value),
    .last       (last)
  );

  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (rst) (in_valid && in_ready) |=> !in_ready
  ) else $error("input accepted while previous word still planned");

  a_sync_word: assert property (
    @(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_SYNC) |->
      (last && dev_num == '0 && key_code == '0 && !key_value)
  ) else $error("sync marker malformed or not final");

  a_load_sets_valid: assert property (
    @(posedge clk) disable iff (rst) cmd.load |=> out_valid
  ) else $error("loaded result not presented");

endmodule

FILE: sv/thkm_ctrl.sv
module thkm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  thkm_pkg::plan_t plan,
  output logic            accept,
  output thkm_pkg::cmd_t  cmd
);
  import thkm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_FIRST,
    ST_SECOND,
    ST_SYNC
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_next;
  logic             can_load;
  logic             first_end;
  logic             second_end;

  assign in_ready   = (state == ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign can_load   = !out_valid || out_ready;
  assign first_end  = (CNT_W'(idx) + CNT_W'(1)) == plan.first_count;
  assign second_end = (CNT_W'(idx) + CNT_W'(1)) == plan.second_count;

  always_comb begin
    state_next = state;
    idx_next   = idx;
    cmd.load   = 1'b0;
    cmd.seg    = SEG_FIRST;
    cmd.idx    = idx;
    cmd.last   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_START;
        end
      end
      ST_START: begin
        idx_next = '0;
        priority if (plan.first_count != '0) begin
          state_next = ST_FIRST;
        end else if (plan.sync) begin
          state_next = ST_SYNC;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_FIRST: begin
        if (can_load) begin
          cmd.load = 1'b1;
          cmd.seg  = SEG_FIRST;
          cmd.last = first_end && (plan.second_count == '0) && !plan.sync;
          if (first_end) begin
            idx_next = '0;
            priority if (plan.second_count != '0) begin
              state_next = ST_SECOND;
            end else if (plan.sync) begin
              state_next = ST_SYNC;
            end else begin
              state_next = ST_IDLE;
            end
          end else begin
            idx_next = idx + IDX_W'(1);
          end
        end
      end
      ST_SECOND: begin
        if (can_load) begin
          cmd.load = 1'b1;
          cmd.seg  = SEG_SECOND;
          cmd.last = second_end;
          if (second_end) begin
            idx_next   = '0;
            state_next = ST_IDLE;
          end else begin
            idx_next = idx + IDX_W'(1);
          end
        end
      end
      ST_SYNC: begin
        if (can_load) begin
          cmd.load   = 1'b1;
          cmd.seg    = SEG_SYNC;
          cmd.last   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: sv/thkm_dp.sv
module thkm_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             accept,
  input  logic                             op,
  input  logic                             pressed,
  input  logic [thkm_pkg::DELTA_W-1:0]     elapsed_ms,
  input  thkm_pkg::cmd_t                   cmd,
  output thkm_pkg::plan_t                  plan,
  input  logic                             cfg_write,
  input  logic [thkm_pkg::REG_SEL_W-1:0]   cfg_sel,
  input  logic [thkm_pkg::DATA_W-1:0]      cfg_wdata,
  output logic [thkm_pkg::DATA_W-1:0]      cfg_rdata,
  output logic                             kind,
  output logic [thkm_pkg::DEV_W-1:0]       dev_num,
  output logic [thkm_pkg::CODE_W-1:0]      key_code,
  output logic                             key_value,
  output logic                             last
);
  import thkm_pkg::*;

  logic [THR_W-1:0]  hold_limit;
  logic [DATA_W-1:0] primary_keys;
  logic [CNT_W-1:0]  primary_count;
  logic [DATA_W-1:0] secondary_keys;
  logic [CNT_W-1:0]  secondary_count;

  logic              held;
  logic              held_next;
  logic [TIME_W-1:0] hold_time;
  logic [TIME_W-1:0] hold_time_next;
  plan_t             plan_next;

  logic [CNT_W-1:0]  prim_n;
  logic [CNT_W-1:0]  sec_n;
  logic [TIME_W-1:0] thr_ext;
  logic [TIME_W-1:0] sum;
  logic              below;
  logic [DATA_W-1:0] keys;
  logic [SLOT_W-1:0] slot;

  assign prim_n  = eff_count(primary_count);
  assign sec_n   = eff_count(secondary_count);
  assign thr_ext = TIME_W'(hold_limit);
  assign sum     = hold_time + TIME_W'(elapsed_ms);
  assign below   = hold_time < thr_ext;

  always_comb begin
    held_next      = held;
    hold_time_next = hold_time;
    plan_next      = '0;
    if (op == OP_LEVEL) begin
      if (pressed != held) begin
        held_next = pressed;
        if (hold_limit == '0) begin
          plan_next.first_value = pressed;
          plan_next.first_count = prim_n;
        end else if (!pressed) begin
          if (below) begin
            plan_next.first_value  = 1'b1;
            plan_next.first_count  = prim_n;
            plan_next.second_count = prim_n;
          end else begin
            plan_next.first_secondary = 1'b1;
            plan_next.first_count     = sec_n;
          end
          hold_time_next = '0;
        end
      end
    end else begin
      if (held && (hold_limit != '0) && below) begin
        if (sum >= thr_ext) begin
          plan_next.first_secondary = 1'b1;
          plan_next.first_value     = 1'b1;
          plan_next.first_count     = sec_n;
          plan_next.sync            = 1'b1;
        end
        hold_time_next = sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= 1'b0;
      hold_time <= '0;
      plan      <= '0;
    end else if (accept) begin
      held      <= held_next;
      hold_time <= hold_time_next;
      plan      <= plan_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_limit      <= '0;
      primary_keys    <= '0;
      primary_count   <= '0;
      secondary_keys  <= '0;
      secondary_count <= '0;
    end else if (cfg_write) begin
      unique case (cfg_sel)
        REG_HOLD_LIMIT:      hold_limit      <= cfg_wdata[THR_W-1:0];
        REG_PRIMARY_KEYS:    primary_keys    <= cfg_wdata;
        REG_PRIMARY_COUNT:   primary_count   <= cfg_wdata[CNT_W-1:0];
        REG_SECONDARY_KEYS:  secondary_keys  <= cfg_wdata;
        REG_SECONDARY_COUNT: secondary_count <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_HOLD_LIMIT:      cfg_rdata = DATA_W'(hold_limit);
      REG_PRIMARY_KEYS:    cfg_rdata = primary_keys;
      REG_PRIMARY_COUNT:   cfg_rdata = DATA_W'(primary_count);
      REG_SECONDARY_KEYS:  cfg_rdata = secondary_keys;
      REG_SECONDARY_COUNT: cfg_rdata = DATA_W'(secondary_count);
      default:             cfg_rdata = '0;
    endcase
  end

  assign keys = (cmd.seg == SEG_FIRST && plan.first_secondary) ? secondary_keys
                                                                 : primary_keys;
  assign slot = keys[SLOT_W*cmd.idx +: SLOT_W];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      last <= cmd.last;
      unique case (cmd.seg)
        SEG_FIRST: begin
          kind      <= KIND_KEY;
          dev_num   <= slot[SLOT_W-1 -: DEV_W];
          key_code  <= slot[CODE_W-1:0];
          key_value <= plan.first_value;
        end
        SEG_SECOND: begin
          kind      <= KIND_KEY;
          dev_num   <= slot[SLOT_W-1 -: DEV_W];
          key_code  <= slot[CODE_W-1:0];
          key_value <= 1'b0;
        end
        default: begin
          kind      <= KIND_SYNC;
          dev_num   <= '0;
          key_code  <= '0;
          key_value <= 1'b0;
        end
      endcase
    end
  end

endmodule
